// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet during rst.
`define FK_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on clk, quiet during rst.
`define FK_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/fk_pkg.sv =====
package fk_pkg;

  localparam int NUM_JOINTS   = 6;
  localparam int CORDIC_STEPS = 30;

  localparam logic [4:0] LAST_STEP   = 5'd28;
  localparam logic [4:0] LAST_CORDIC = 5'(CORDIC_STEPS - 1);

  localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [35:0] TWO_PI_Q30  = 36'sd6746518852;
  localparam logic signed [35:0] ONE_Q30     = 36'sd1073741824;
  localparam logic signed [35:0] TR_BOUND    = 36'sd4294967296;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  typedef enum logic [1:0] {KIND_RX, KIND_RY, KIND_RZ, KIND_TR} kind_t;

  typedef struct packed {
    kind_t      kind;
    logic       use_joint;
    logic [2:0] joint;
    logic [4:0] pidx;
    logic [1:0] nparams;
    logic       add_track;
  } step_t;

  typedef struct packed {
    logic       valid;
    logic       first;
    logic       last;
    logic [1:0] r;
    logic [1:0] k;
  } mac_ctl_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_STEP, ST_RD, ST_CAP, ST_SC_START, ST_SC_WAIT,
    ST_MAC, ST_DRAIN, ST_NEXT, ST_OUT
  } fk_state_t;

  typedef enum logic [1:0] {CS_IDLE, CS_REDUCE, CS_ITER, CS_FINISH} cordic_state_t;

  // The chain of elementary transforms, one entry per step.
  function automatic step_t step_info(input logic [4:0] s);
    step_t      st;
    logic [4:0] d;
    st = '{kind: KIND_TR, use_joint: 1'b0, joint: 3'd0, pidx: 5'd0,
           nparams: 2'd1, add_track: 1'b0};
    d = s - 5'd4;
    if (s < 5'd4) begin
      st.pidx = s;
      unique case (s[1:0])
        2'd0: st.kind = KIND_RX;
        2'd1: st.kind = KIND_RY;
        2'd2: st.kind = KIND_RZ;
        default: begin
          st.kind = KIND_TR;
          st.nparams = 2'd3;
          st.add_track = 1'b1;
        end
      endcase
    end else if (s < 5'd24) begin
      st.pidx = s + 5'd1;
      st.joint = d[4:2];
      unique case (d[1:0])
        2'd0: begin
          st.kind = KIND_RZ;
          st.use_joint = 1'b1;
          st.nparams = 2'd0;
        end
        2'd1: st.kind = KIND_RX;
        2'd2: st.kind = KIND_RY;
        default: begin
          st.kind = KIND_TR;
          st.nparams = 2'd2;
        end
      endcase
    end else begin
      st.pidx = s + 5'd1;
      unique case (s)
        5'd24: begin
          st.kind = KIND_RZ;
          st.use_joint = 1'b1;
          st.joint = 3'd5;
          st.nparams = 2'd0;
        end
        5'd25: st.kind = KIND_RX;
        5'd26: st.kind = KIND_RY;
        5'd27: st.kind = KIND_RZ;
        default: begin
          st.kind = KIND_TR;
          st.nparams = 2'd3;
        end
      endcase
    end
    return st;
  endfunction

  function automatic logic [31:0] atan_q30(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'h3243F6A8;
      5'd1:  v = 32'h1DAC6705;
      5'd2:  v = 32'h0FADBAFC;
      5'd3:  v = 32'h07F56EA6;
      5'd4:  v = 32'h03FEAB76;
      5'd5:  v = 32'h01FFD55B;
      5'd6:  v = 32'h00FFFAAA;
      5'd7:  v = 32'h007FFF55;
      5'd8:  v = 32'h003FFFEA;
      5'd9:  v = 32'h001FFFFD;
      5'd10: v = 32'h000FFFFF;
      default: v = (32'h1 << (6'd30 - 6'(i))) - 32'h1;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] clamp_unit(input logic signed [35:0] v);
    logic signed [35:0] c;
    c = (v > ONE_Q30) ? ONE_Q30 : ((v < -ONE_Q30) ? -ONE_Q30 : v);
    return c[31:0];
  endfunction

endpackage

// ===== rtl/fk_ram.sv =====
module fk_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/fk_cordic.sv =====
module fk_cordic import fk_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] angle,
  output logic               done,
  output logic signed [31:0] cos_q30,
  output logic signed [31:0] sin_q30
);

  cordic_state_t      state, state_next;
  logic signed [35:0] z;
  logic signed [33:0] x, y;
  logic signed [35:0] at_ext;
  logic               neg;
  logic [4:0]         i;

  assign at_ext = {4'b0, atan_q30(i)};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    done = 1'b0;
    unique case (state)
      CS_IDLE: begin
        if (start) state_next = CS_REDUCE;
      end
      CS_REDUCE: begin
        if (!(z > PI_Q30) && !(z < -PI_Q30)) state_next = CS_ITER;
      end
      CS_ITER: begin
        if (i == LAST_CORDIC) state_next = CS_FINISH;
      end
      CS_FINISH: begin
        done = 1'b1;
        state_next = CS_IDLE;
      end
      default: state_next = CS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      CS_IDLE: begin
        if (start) begin
          z <= {{2{angle[31]}}, angle, 2'b00};
          neg <= 1'b0;
        end
      end
      CS_REDUCE: begin
        if (z > PI_Q30) begin
          z <= z - TWO_PI_Q30;
        end else if (z < -PI_Q30) begin
          z <= z + TWO_PI_Q30;
        end else begin
          // Fold into the right half plane; both results flip sign.
          if (z > HALF_PI_Q30) begin
            z <= z - PI_Q30;
            neg <= 1'b1;
          end else if (z < -HALF_PI_Q30) begin
            z <= z + PI_Q30;
            neg <= 1'b1;
          end
          x <= CORDIC_GAIN;
          y <= 34'sd0;
          i <= 5'd0;
        end
      end
      CS_ITER: begin
        if (!z[35]) begin
          x <= x - (y >>> i);
          y <= y + (x >>> i);
          z <= z - at_ext;
        end else begin
          x <= x + (y >>> i);
          y <= y - (x >>> i);
          z <= z + at_ext;
        end
        i <= i + 5'd1;
      end
      default: begin
        cos_q30 <= clamp_unit(neg ? -36'(x) : 36'(x));
        sin_q30 <= clamp_unit(neg ? -36'(y) : 36'(y));
      end
    endcase
  end

endmodule

// ===== rtl/fk_mac.sv =====
module fk_mac import fk_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  mac_ctl_t           issue,
  input  logic signed [31:0] op_a,
  input  logic signed [33:0] op_b,
  input  logic signed [35:0] base,
  output mac_ctl_t           held,
  output logic signed [35:0] sum
);

  logic signed [65:0] prod;
  logic signed [35:0] acc;
  logic signed [65:0] rounded;

  // Each product is rounded to Q30 on its own before it is summed.
  assign rounded = (prod + 66'sd536870912) >>> 30;
  assign sum = (held.first ? base : acc) + rounded[35:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '0;
    end else begin
      held <= issue;
    end
  end

  always_ff @(posedge clk) begin
    prod <= 66'(op_a) * 66'(op_b);
    if (held.valid) begin
      acc <= sum;
    end
  end

endmodule

// ===== rtl/robot_pose_forward_kinematics_unit.sv =====
// A parameter write is taken while idle. A pose is worked through in 29 transform steps:
// 22 rotations (a 30-step CORDIC, then 27 issues of the shared multiplier) and 7 translations.
// The twelve result words then leave at up to one per cycle, as m_tready allows; one item
// is in work at a time.
// Reset returns the sequencer to idle; the calibration table is undefined until written.
module robot_pose_forward_kinematics_unit import fk_pkg::*; #(
  parameter int DATA_WIDTH = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // param_index[4:0], param_value[36:5], track_offset[68:37],
  // joint_1[100:69] .. joint_6[260:229], zero fill
  input  logic [263:0] s_tdata,
  // op[0]
  input  logic         s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // row[1:0], col[3:2], value[35:4], zero fill
  output logic [39:0]  m_tdata,
  output logic         m_tlast
);

  localparam int SAT_BITS = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
  localparam logic signed [35:0] SAT_HI = 36'((64'sd1 <<< (SAT_BITS - 1)) - 64'sd1);
  localparam logic signed [35:0] SAT_LO = -SAT_HI - 36'sd1;
  localparam int JOINT_LSB = 69;
  localparam logic [3:0] LAST_WORD = 4'd11;
  localparam logic [1:0] COL_TRANS = 2'd3;

  fk_state_t          state, state_next;
  step_t              info;
  logic [4:0]         step;
  logic [1:0]         cnt;
  logic signed [31:0] pslot [3];
  logic signed [31:0] joint [NUM_JOINTS];
  logic signed [31:0] track;
  logic signed [31:0] rot [9];
  logic signed [31:0] tmat [9];
  logic signed [35:0] tr [3];
  logic [1:0]         r, k, t;
  logic [3:0]         oc;

  logic               ram_we;
  logic [4:0]         ram_raddr;
  logic [31:0]        ram_rdata;

  logic               sc_start, sc_done;
  logic signed [31:0] sc_angle, c_q30, s_q30;

  mac_ctl_t           issue, held;
  logic signed [31:0] op_a;
  logic signed [33:0] op_b, tx, ty, tz;
  logic signed [35:0] mac_base, mac_sum;
  logic [3:0]         ridx;
  logic               issue_end;

  logic [1:0]         orow, ocol;
  logic [3:0]         oidx;
  logic signed [35:0] osrc, osat;

  function automatic logic signed [35:0] clamp_tr(input logic signed [35:0] v);
    return (v > TR_BOUND) ? TR_BOUND : ((v < -TR_BOUND) ? -TR_BOUND : v);
  endfunction

  // Entry (bt, bk) of the elementary rotation matrix for this step.
  function automatic logic signed [33:0] bsel(input kind_t kind, input logic [1:0] bt,
                                              input logic [1:0] bk,
                                              input logic signed [31:0] c,
                                              input logic signed [31:0] s);
    logic signed [33:0] one, cc, ss, v;
    one = ONE_Q30[33:0];
    cc = 34'(c);
    ss = 34'(s);
    v = 34'sd0;
    case (kind)
      KIND_RX: begin
        case ({bt, bk})
          4'b0000: v = one;
          4'b0101: v = cc;
          4'b0110: v = -ss;
          4'b1001: v = ss;
          4'b1010: v = cc;
          default: v = 34'sd0;
        endcase
      end
      KIND_RY: begin
        case ({bt, bk})
          4'b0101: v = one;
          4'b0000: v = cc;
          4'b0010: v = ss;
          4'b1000: v = -ss;
          4'b1010: v = cc;
          default: v = 34'sd0;
        endcase
      end
      default: begin
        case ({bt, bk})
          4'b1010: v = one;
          4'b0000: v = cc;
          4'b0001: v = -ss;
          4'b0100: v = ss;
          4'b0101: v = cc;
          default: v = 34'sd0;
        endcase
      end
    endcase
    return v;
  endfunction

  assign info = step_info(step);
  assign ram_raddr = info.pidx + 5'(cnt);

  fk_ram #(.WIDTH(32), .DEPTH(32)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s_tdata[4:0]),
    .wdata (s_tdata[36:5]),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign sc_angle = info.use_joint ? joint[info.joint] : pslot[0];

  fk_cordic u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (sc_start),
    .angle   (sc_angle),
    .done    (sc_done),
    .cos_q30 (c_q30),
    .sin_q30 (s_q30)
  );

  assign tx = 34'(pslot[0]) + (info.add_track ? 34'(track) : 34'sd0);
  assign ty = 34'(pslot[1]);
  assign tz = (info.nparams == 2'd3) ? 34'(pslot[2]) : 34'sd0;

  assign ridx = 4'(r) * 4'd3 + 4'(t);
  assign op_a = rot[ridx];
  always_comb begin
    if (info.kind == KIND_TR) begin
      op_b = (t == 2'd0) ? tx : ((t == 2'd1) ? ty : tz);
    end else begin
      op_b = bsel(info.kind, t, k, c_q30, s_q30);
    end
  end

  assign issue.valid = (state == ST_MAC);
  assign issue.first = (t == 2'd0);
  assign issue.last  = (t == 2'd2);
  assign issue.r     = r;
  assign issue.k     = k;
  assign issue_end = (r == 2'd2) && (t == 2'd2) && ((info.kind == KIND_TR) || (k == 2'd2));

  // A translation accumulates onto the row's current offset.
  assign mac_base = (info.kind == KIND_TR) ? tr[held.r] : 36'sd0;

  fk_mac u_mac (
    .clk   (clk),
    .rst   (rst),
    .issue (issue),
    .op_a  (op_a),
    .op_b  (op_b),
    .base  (mac_base),
    .held  (held),
    .sum   (mac_sum)
  );

  assign orow = oc[3:2];
  assign ocol = oc[1:0];
  assign oidx = 4'(orow) * 4'd3 + 4'(ocol);
  assign osrc = (ocol == COL_TRANS) ? tr[orow] : 36'(rot[oidx]);
  assign osat = (osrc > SAT_HI) ? SAT_HI : ((osrc < SAT_LO) ? SAT_LO : osrc);
  assign m_tdata = {4'b0, osat[31:0], ocol, orow};
  assign m_tlast = (oc == LAST_WORD);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready = 1'b0;
    m_tvalid = 1'b0;
    sc_start = 1'b0;
    ram_we = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          if (s_tuser) ram_we = 1'b1;
          else state_next = ST_STEP;
        end
      end
      ST_STEP: begin
        if (info.kind != KIND_TR && info.use_joint) state_next = ST_SC_START;
        else state_next = ST_RD;
      end
      ST_RD: state_next = ST_CAP;
      ST_CAP: begin
        if (cnt == info.nparams - 2'd1) begin
          state_next = (info.kind == KIND_TR) ? ST_MAC : ST_SC_START;
        end else begin
          state_next = ST_RD;
        end
      end
      ST_SC_START: begin
        sc_start = 1'b1;
        state_next = ST_SC_WAIT;
      end
      ST_SC_WAIT: begin
        if (sc_done) state_next = ST_MAC;
      end
      ST_MAC: begin
        if (issue_end) state_next = ST_DRAIN;
      end
      ST_DRAIN: state_next = ST_NEXT;
      ST_NEXT: begin
        state_next = (step == LAST_STEP) ? ST_OUT : ST_STEP;
      end
      ST_OUT: begin
        m_tvalid = 1'b1;
        if (m_tready && oc == LAST_WORD) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (s_tvalid && !s_tuser) begin
          track <= s_tdata[68:37];
          for (int j = 0; j < NUM_JOINTS; j++) begin
            joint[j] <= s_tdata[JOINT_LSB + 32 * j +: 32];
          end
          for (int e = 0; e < 9; e++) begin
            rot[e] <= (e == 0 || e == 4 || e == 8) ? ONE_Q30[31:0] : 32'sd0;
          end
          for (int e = 0; e < 3; e++) begin
            tr[e] <= 36'sd0;
          end
          step <= 5'd0;
        end
      end
      ST_STEP: begin
        cnt <= 2'd0;
        r <= 2'd0;
        k <= 2'd0;
        t <= 2'd0;
      end
      ST_CAP: begin
        pslot[cnt] <= ram_rdata;
        cnt <= cnt + 2'd1;
      end
      ST_MAC: begin
        if (t == 2'd2) begin
          t <= 2'd0;
          if (info.kind == KIND_TR || k == 2'd2) begin
            k <= 2'd0;
            r <= r + 2'd1;
          end else begin
            k <= k + 2'd1;
          end
        end else begin
          t <= t + 2'd1;
        end
      end
      ST_NEXT: begin
        if (info.kind != KIND_TR) begin
          for (int e = 0; e < 9; e++) begin
            rot[e] <= tmat[e];
          end
        end
        if (step != LAST_STEP) step <= step + 5'd1;
        oc <= 4'd0;
      end
      ST_OUT: begin
        if (m_tready) oc <= oc + 4'd1;
      end
      default: ;
    endcase
    if (held.valid && held.last) begin
      if (info.kind == KIND_TR) begin
        tr[held.r] <= clamp_tr(mac_sum);
      end else begin
        tmat[4'(held.r) * 4'd3 + 4'(held.k)] <= clamp_unit(mac_sum);
      end
    end
  end

endmodule

// ===== rtl/fk_checker.sv =====
`include "assert_macros.svh"

module fk_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [39:0]  m_tdata,
  input logic         m_tlast
);

  // A stalled word keeps its contents.
  `FK_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

  // The block never takes a new word while results are pending.
  `FK_ASSERT_NOW(a_no_overlap, m_tvalid, !s_tready)

  // The final word of a pose is row two, translation column.
  `FK_ASSERT_NOW(a_last_pos, m_tvalid && m_tlast, m_tdata[3:0] == 4'hE)

  // Once the final word is taken the block is ready again.
  `FK_ASSERT_NEXT(a_ready_after, m_tvalid && m_tready && m_tlast, s_tready && !m_tvalid)

endmodule

bind robot_pose_forward_kinematics_unit fk_checker u_fk_checker (.*);

// ===== verif/testbench.sv =====
module testbench;
  import fk_pkg::*;

  localparam logic OP_POSE  = 1'b0;
  localparam logic OP_WRITE = 1'b1;
  localparam int   N_PARAMS = 32;
  localparam int   WORD_CYCLES = 2000;
  localparam longint CYCLE_LIMIT = 3000000;
  localparam longint Q30_ONE = 64'sd1073741824;
  localparam longint TRANS_BOUND = 64'sd4294967296;
  localparam longint PI_V = 64'sd3373259426;
  localparam longint HALF_PI_V = 64'sd1686629713;
  localparam longint TWO_PI_V = 64'sd6746518852;
  localparam longint GAIN_V = 64'sd652032874;
  localparam int   AX_X = 0;
  localparam int   AX_Y = 1;
  localparam int   AX_Z = 2;

  typedef struct packed {
    logic [1:0]  row;
    logic [1:0]  col;
    logic [31:0] value;
    logic        last;
  } pose_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [263:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic m_tlast;

  robot_pose_forward_kinematics_unit u_dut (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .s_tdata(s_tdata), .s_tuser(s_tuser), .m_tvalid(m_tvalid),
    .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  logic [31:0] calib_copy [N_PARAMS];
  longint rot_m [3][3];
  longint trans_v [3];
  pose_word_t pending_words [$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  longint cycles = 0;

  function automatic longint shr_arith(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint limit(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint fix_mul(longint a, longint b);
    return (a * b + (64'sd1 << 29)) >>> 30;
  endfunction

  function automatic longint atan_entry(int i);
    longint tbl [11] = '{64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
      64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA,
      64'h001FFFFD, 64'h000FFFFF};
    if (i < 11) return tbl[i];
    return (64'sd1 <<< (30 - i)) - 1;
  endfunction

  task automatic sin_cos(input longint a28, output longint c, output longint s);
    longint z, x, y, nx;
    bit flip;
    z = a28 * 4;
    x = GAIN_V;
    y = 0;
    flip = 0;
    while (z > PI_V) z -= TWO_PI_V;
    while (z < -PI_V) z += TWO_PI_V;
    if (z > HALF_PI_V) begin
      z -= PI_V;
      flip = 1;
    end else if (z < -HALF_PI_V) begin
      z += PI_V;
      flip = 1;
    end
    for (int i = 0; i < 30; i++) begin
      if (z >= 0) begin
        nx = x - shr_arith(y, i); y = y + shr_arith(x, i); z -= atan_entry(i);
      end else begin
        nx = x + shr_arith(y, i); y = y - shr_arith(x, i); z += atan_entry(i);
      end
      x = nx;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    c = limit(x, -Q30_ONE, Q30_ONE);
    s = limit(y, -Q30_ONE, Q30_ONE);
  endtask

  task automatic rotate(input int axis, input longint a28);
    longint c, s;
    longint b [3][3];
    longint t [3][3];
    sin_cos(a28, c, s);
    b = '{default: 0};
    if (axis == AX_X) begin
      b[0][0] = Q30_ONE; b[1][1] = c; b[1][2] = -s; b[2][1] = s; b[2][2] = c;
    end else if (axis == AX_Y) begin
      b[1][1] = Q30_ONE; b[0][0] = c; b[0][2] = s; b[2][0] = -s; b[2][2] = c;
    end else begin
      b[2][2] = Q30_ONE; b[0][0] = c; b[0][1] = -s; b[1][0] = s; b[1][1] = c;
    end
    for (int r = 0; r < 3; r++)
      for (int k = 0; k < 3; k++)
        t[r][k] = limit(fix_mul(rot_m[r][0], b[0][k]) + fix_mul(rot_m[r][1], b[1][k]) +
                        fix_mul(rot_m[r][2], b[2][k]), -Q30_ONE, Q30_ONE);
    rot_m = t;
  endtask

  task automatic translate(input longint x, input longint y, input longint z);
    x = limit(x, -TRANS_BOUND, TRANS_BOUND);
    y = limit(y, -TRANS_BOUND, TRANS_BOUND);
    z = limit(z, -TRANS_BOUND, TRANS_BOUND);
    for (int r = 0; r < 3; r++)
      trans_v[r] = limit(trans_v[r] + fix_mul(rot_m[r][0], x) + fix_mul(rot_m[r][1], y) +
                         fix_mul(rot_m[r][2], z), -TRANS_BOUND, TRANS_BOUND);
  endtask

  function automatic longint calib(int i);
    return longint'($signed(calib_copy[i]));
  endfunction

  task automatic predict_pose(input logic [31:0] track, input logic [31:0] joints [6]);
    pose_word_t w;
    longint v;
    int b;
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) rot_m[r][k] = (r == k) ? Q30_ONE : 0;
      trans_v[r] = 0;
    end
    rotate(AX_X, calib(0));
    rotate(AX_Y, calib(1));
    rotate(AX_Z, calib(2));
    translate(calib(3) + longint'($signed(track)), calib(4), calib(5));
    for (int j = 0; j < 5; j++) begin
      b = 6 + 4 * j;
      rotate(AX_Z, longint'($signed(joints[j])));
      rotate(AX_X, calib(b));
      rotate(AX_Y, calib(b + 1));
      translate(calib(b + 2), calib(b + 3), 0);
    end
    rotate(AX_Z, longint'($signed(joints[5])));
    rotate(AX_X, calib(26));
    rotate(AX_Y, calib(27));
    rotate(AX_Z, calib(28));
    translate(calib(29), calib(30), calib(31));
    for (int r = 0; r < 3; r++)
      for (int k = 0; k < 4; k++) begin
        v = limit(k < 3 ? rot_m[r][k] : trans_v[r], -64'sd2147483648, 64'sd2147483647);
        w.row = 2'(r);
        w.col = 2'(k);
        w.value = v[31:0];
        w.last = (r == 2 && k == 3);
        pending_words = {pending_words, w};
      end
  endtask

  // The valid line stays high from one word to the next unless the sender idles.
  task automatic send_word(input logic op, input logic [4:0] idx, input logic [31:0] val,
                           input logic [31:0] track, input logic [31:0] joints [6]);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tuser <= op;
    s_tdata <= {3'b0, joints[5], joints[4], joints[3], joints[2], joints[1], joints[0],
                track, val, idx};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (op == OP_WRITE) calib_copy[idx] = val;
    else predict_pose(track, joints);
  endtask

  task automatic write_param(input int idx, input logic [31:0] val);
    logic [31:0] jz [6] = '{default: 0};
    send_word(OP_WRITE, 5'(idx), val, $urandom, jz);
  endtask

  task automatic random_pose();
    logic [31:0] j [6];
    logic [31:0] tr;
    for (int i = 0; i < 6; i++) j[i] = $urandom;
    tr = ($urandom_range(3) == 0) ? $urandom : 32'($signed($urandom_range(0, 2000000)) -
                                                   1000000) <<< 4;
    send_word(OP_POSE, 5'($urandom), $urandom, tr, j);
  endtask

  function automatic logic [31:0] random_param();
    int m;
    m = $urandom_range(9);
    if (m == 0) return 32'h7FFFFFFF;
    if (m == 1) return 32'h80000000;
    if (m == 2) return 32'h0;
    if (m < 5) return $urandom;
    return 32'($signed($urandom_range(0, 200000000)) - 100000000);
  endfunction

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (WORD_CYCLES) @(posedge clk);
  endtask

  // Result monitor: the receiver stalls at random, the check runs on each accepted word.
  always @(posedge clk) begin
    pose_word_t got, want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got.row = m_tdata[1:0];
        got.col = m_tdata[3:2];
        got.value = m_tdata[35:4];
        got.last = m_tlast;
        if (pending_words.size() == 0) begin
          $error("unexpected word row=%0d col=%0d value=%h", got.row, got.col, got.value);
          errors++;
        end else begin
          want = pending_words.pop_front();
          if (got.row !== want.row) begin
            $error("row: expected %0d actual %0d", want.row, got.row); errors++;
          end
          if (got.col !== want.col) begin
            $error("col: expected %0d actual %0d", want.col, got.col); errors++;
          end
          if (got.value !== want.value) begin
            $error("value: expected %h actual %h", want.value, got.value); errors++;
          end
          if (got.last !== want.last) begin
            $error("last: expected %0b actual %0b", want.last, got.last); errors++;
          end
        end
      end
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // Directed rows: op, index, value; poses use the joint and track columns.
  typedef struct {
    logic        op;
    logic [4:0]  idx;
    logic [31:0] val;
    logic [31:0] track;
    logic [31:0] j1;
    logic [31:0] j6;
  } row_t;

  row_t directed [] = '{
    '{OP_POSE, 5'd31, 32'hFFFFFFFF, 32'h0, 32'h0, 32'h0},
    '{OP_POSE, 5'd0, 32'h0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000},
    '{OP_POSE, 5'd0, 32'h0, 32'h80000000, 32'h80000000, 32'h7FFFFFFF},
    '{OP_POSE, 5'd0, 32'h0, 32'h0, 32'h1921FB54, 32'hE6DE04AC},
    '{OP_POSE, 5'd0, 32'h0, 32'h0, 32'h3243F6A8, 32'h3243F6A9},
    '{OP_POSE, 5'd0, 32'h0, 32'hFFFFFFFF, 32'h1921FB55, 32'hCDBC0958}
  };

  initial begin
    logic [31:0] jv [6];
    int phase;
    for (int i = 0; i < N_PARAMS; i++) calib_copy[i] = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int i = 0; i < N_PARAMS; i++) write_param(i, 32'h0);
    for (int n = 0; n < directed.size(); n++) begin
      jv = '{default: 0};
      jv[0] = directed[n].j1;
      jv[5] = directed[n].j6;
      jv[2] = directed[n].j1 ^ directed[n].j6;
      send_word(directed[n].op, directed[n].idx, directed[n].val, directed[n].track, jv);
    end
    drain();
    // Extreme calibration: every entry at the positive, then negative limit.
    for (int e = 0; e < 2; e++) begin
      for (int i = 0; i < N_PARAMS; i++) write_param(i, e ? 32'h80000000 : 32'h7FFFFFFF);
      random_pose();
      drain();
    end
    for (int n = 0; n < 90; n++) begin
      phase = n / 30;
      send_idle_pct = (phase == 0) ? 35 : (phase == 1 ? 78 : 0);
      recv_idle_pct = (phase == 0) ? 78 : (phase == 1 ? 35 : 0);
      if (n % 45 == 0) begin
        drain();
        for (int i = 0; i < N_PARAMS; i++) write_param(i, random_param());
      end
      if ($urandom_range(7) == 0) begin
        // A table write mixed into the pose stream.
        write_param($urandom_range(31), random_param());
      end
      random_pose();
    end
    drain();
    if (errors == 0) $display("testbench: done, clean");
    else $display("testbench: done, errors");
    $finish;
  end
endmodule
